// ===== src/pmt_pkg.sv =====
`timescale 1ns / 1ps

package pmt_pkg;

   localparam int POS_W       = 10;
   localparam int BUTTON_W    = 3;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_X_LIMIT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_LIMIT = 1'b1;

   localparam logic [POS_W-1:0] X_LIMIT_RESET  = 10'd319;
   localparam logic [POS_W-1:0] Y_LIMIT_RESET  = 10'd199;
   localparam logic [POS_W-1:0] CURSOR_X_RESET = 10'd160;
   localparam logic [POS_W-1:0] CURSOR_Y_RESET = 10'd100;

   localparam int                  SYNC_BIT    = 3;
   localparam logic [BUTTON_W-1:0] BUTTON_NONE = 3'b000;

   typedef enum logic [1:0] {
      ST_IGNORED  = 2'd0,
      ST_DROPPED  = 2'd1,
      ST_STORED   = 2'd2,
      ST_COMPLETE = 2'd3
   } byte_status_type;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_XDELTA = 2'd1,
      PH_YDELTA = 2'd2
   } phase_type;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
      logic       buffer_full;
      logic       from_aux;
   } req_item_type;

   typedef struct packed {
      byte_status_type     byte_status;
      logic [POS_W-1:0]    pos_x;
      logic [POS_W-1:0]    pos_y;
      logic [BUTTON_W-1:0] button_state;
      logic [BUTTON_W-1:0] click_mask;
   } rsp_item_type;

   typedef struct packed {
      logic                   write_en;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  wdata;
   } csr_write_type;

endpackage

// ===== src/pmt_req_if.sv =====
`timescale 1ns / 1ps

interface pmt_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] data_byte;
   logic       buffer_full;
   logic       from_aux;

   modport source (output valid, output func, output data_byte, output buffer_full,
                   output from_aux, input ready);
   modport sink   (input valid, input func, input data_byte, input buffer_full,
                   input from_aux, output ready);
endinterface

// ===== src/pmt_rsp_if.sv =====
`timescale 1ns / 1ps

interface pmt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] byte_status;
   logic [9:0] pos_x;
   logic [9:0] pos_y;
   logic [2:0] button_state;
   logic [2:0] click_mask;

   modport source (output valid, output byte_status, output pos_x, output pos_y,
                   output button_state, output click_mask, input ready);
   modport sink   (input valid, input byte_status, input pos_x, input pos_y,
                   input button_state, input click_mask, output ready);
endinterface

// ===== src/pmt_item_reg.sv =====
`timescale 1ns / 1ps

module pmt_item_reg (
   input  logic                 clock,
   input  logic                 reset,
   pmt_req_if.sink              req_if,
   input  logic                 advance,
   output logic                 item_valid,
   output pmt_pkg::req_item_type item
);
   import pmt_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         transfer;

   assign req_if.ready = !valid_ff || advance;
   assign transfer     = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (transfer) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (transfer) begin
         item_ff.func        <= req_if.func;
         item_ff.data_byte   <= req_if.data_byte;
         item_ff.buffer_full <= req_if.buffer_full;
         item_ff.from_aux    <= req_if.from_aux;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== src/pmt_tracker_core.sv =====
`timescale 1ns / 1ps

module pmt_tracker_core (
   input  logic                  clock,
   input  logic                  reset,
   input  pmt_pkg::csr_write_type csr,
   input  logic                  fire,
   input  pmt_pkg::req_item_type item,
   output pmt_pkg::rsp_item_type result
);
   import pmt_pkg::*;

   logic [POS_W-1:0]    x_limit_ff;
   logic [POS_W-1:0]    y_limit_ff;

   phase_type           phase_ff, phase_in;
   logic [7:0]          header_ff, header_in;
   logic [7:0]          x_delta_ff, x_delta_in;
   logic [POS_W-1:0]    cursor_x_ff, cursor_x_in;
   logic [POS_W-1:0]    cursor_y_ff, cursor_y_in;
   logic [BUTTON_W-1:0] held_ff, held_in;
   logic [BUTTON_W-1:0] clicks_ff, clicks_in;

   byte_status_type     status;
   logic [BUTTON_W-1:0] clicks_out;
   logic signed [POS_W+1:0] next_x;
   logic signed [POS_W+1:0] next_y;
   logic [POS_W-1:0]    clamp_x;
   logic [POS_W-1:0]    clamp_y;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_limit_ff <= X_LIMIT_RESET;
         y_limit_ff <= Y_LIMIT_RESET;
      end else if (csr.write_en) begin
         unique case (csr.index)
            CSR_X_LIMIT: x_limit_ff <= csr.wdata[POS_W-1:0];
            CSR_Y_LIMIT: y_limit_ff <= csr.wdata[POS_W-1:0];
            default:     ;
         endcase
      end
   end

   // signed moves and clamps
   assign next_x = $signed({2'b00, cursor_x_ff})
                 + $signed({{(POS_W-6){x_delta_ff[7]}}, x_delta_ff});
   assign next_y = $signed({2'b00, cursor_y_ff})
                 - $signed({{(POS_W-6){item.data_byte[7]}}, item.data_byte});

   always_comb begin
      if (next_x[POS_W+1]) begin
         clamp_x = '0;
      end else if (next_x[POS_W:0] > {1'b0, x_limit_ff}) begin
         clamp_x = x_limit_ff;
      end else begin
         clamp_x = next_x[POS_W-1:0];
      end
      if (next_y[POS_W+1]) begin
         clamp_y = '0;
      end else if (next_y[POS_W:0] > {1'b0, y_limit_ff}) begin
         clamp_y = y_limit_ff;
      end else begin
         clamp_y = next_y[POS_W-1:0];
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      header_in   = header_ff;
      x_delta_in  = x_delta_ff;
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      held_in     = held_ff;
      clicks_in   = clicks_ff;
      status      = ST_IGNORED;
      clicks_out  = clicks_ff;
      if (item.func) begin
         clicks_out = clicks_ff;
         clicks_in  = BUTTON_NONE;
      end else begin
         if (item.buffer_full && item.from_aux) begin
            unique case (phase_ff)
               PH_XDELTA: begin
                  x_delta_in = item.data_byte;
                  phase_in   = PH_YDELTA;
                  status     = ST_STORED;
               end
               PH_YDELTA: begin
                  phase_in    = PH_HEADER;
                  cursor_x_in = clamp_x;
                  cursor_y_in = clamp_y;
                  held_in     = header_ff[BUTTON_W-1:0];
                  clicks_in   = clicks_ff | (header_ff[BUTTON_W-1:0] & ~held_ff);
                  status      = ST_COMPLETE;
               end
               default: begin
                  header_in = item.data_byte;
                  if (item.data_byte[SYNC_BIT]) begin
                     phase_in = PH_XDELTA;
                     status   = ST_STORED;
                  end else begin
                     phase_in = PH_HEADER;
                     status   = ST_DROPPED;
                  end
               end
            endcase
         end
         clicks_out = clicks_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         header_ff   <= '0;
         x_delta_ff  <= '0;
         cursor_x_ff <= CURSOR_X_RESET;
         cursor_y_ff <= CURSOR_Y_RESET;
         held_ff     <= BUTTON_NONE;
         clicks_ff   <= BUTTON_NONE;
      end else if (fire) begin
         phase_ff    <= phase_in;
         header_ff   <= header_in;
         x_delta_ff  <= x_delta_in;
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         held_ff     <= held_in;
         clicks_ff   <= clicks_in;
      end
   end

   assign result.byte_status  = status;
   assign result.pos_x        = cursor_x_in;
   assign result.pos_y        = cursor_y_in;
   assign result.button_state = held_in;
   assign result.click_mask   = clicks_out;

   a_complete_rephase: assert property (@(posedge clock) disable iff (reset)
      fire && (status == ST_COMPLETE) |=> (phase_ff == PH_HEADER))
      else $error("phase not back to header after complete packet");

   a_clamp_x: assert property (@(posedge clock) disable iff (reset)
      fire && (status == ST_COMPLETE) && !csr.write_en |=> (cursor_x_ff <= x_limit_ff))
      else $error("cursor x beyond limit after packet");

   a_clamp_y: assert property (@(posedge clock) disable iff (reset)
      fire && (status == ST_COMPLETE) && !csr.write_en |=> (cursor_y_ff <= y_limit_ff))
      else $error("cursor y beyond limit after packet");

   a_click_clear: assert property (@(posedge clock) disable iff (reset)
      fire && item.func |=> (clicks_ff == BUTTON_NONE))
      else $error("click mask not cleared on read");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(clicks_ff) && $stable(cursor_x_ff) && $stable(phase_ff))
      else $error("tracker state moved without a transfer");

endmodule

// ===== src/pmt_result_reg.sv =====
`timescale 1ns / 1ps

module pmt_result_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  pmt_pkg::rsp_item_type result,
   output logic                  free,
   pmt_rsp_if.source             rsp_if
);
   import pmt_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type result_ff;

   assign free = !valid_ff || rsp_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_if.valid        = valid_ff;
   assign rsp_if.byte_status  = result_ff.byte_status;
   assign rsp_if.pos_x        = result_ff.pos_x;
   assign rsp_if.pos_y        = result_ff.pos_y;
   assign rsp_if.button_state = result_ff.button_state;
   assign rsp_if.click_mask   = result_ff.click_mask;

endmodule

// ===== src/ps2_mouse_packet_tracker_unit.sv =====
`timescale 1ns / 1ps

// PS/2 mouse packet tracker. Takes one controller byte or click-mask read per
// clock and returns one result for each; a result passes through the input
// register, then the result register fed by the state update, and back-pressure
// on the result side stalls the input only once both registers hold an item.
// Bytes without buffer-full and aux status are ignored, a header without bit 3
// is dropped for resync, and every third stored byte completes a packet that
// moves and clamps the cursor. The user writes the limit registers through the
// csr port while no item is in flight; the block itself does not enforce it.

module ps2_mouse_packet_tracker_unit (
   input  logic                             clock,
   input  logic                             reset,
   pmt_req_if.sink                          req_if,
   pmt_rsp_if.source                        rsp_if,
   input  logic                             csr_write_en,
   input  logic [pmt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pmt_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pmt_pkg::*;

   logic          item_valid;
   req_item_type  item;
   rsp_item_type  result;
   logic          out_free;
   logic          fire;
   csr_write_type csr;

   assign fire         = item_valid && out_free;
   assign csr.write_en = csr_write_en;
   assign csr.index    = csr_index;
   assign csr.wdata    = csr_wdata;

   pmt_item_reg u_item_reg (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .advance    (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   pmt_tracker_core u_core (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   pmt_result_reg u_result_reg (
      .clock  (clock),
      .reset  (reset),
      .load   (fire),
      .result (result),
      .free   (out_free),
      .rsp_if (rsp_if)
   );

endmodule

// ===== bench/pmt_tracker_checker.sv =====
`timescale 1ns / 1ps

module pmt_tracker_checker (
   input  logic                            clock,
   input  logic                            reset,
   pmt_req_if                              req_mon,
   pmt_rsp_if                              rsp_mon,
   input  logic                            csr_write_en,
   input  logic [pmt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pmt_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              mismatches,
   output int                              outstanding
);
   import pmt_pkg::*;

   logic [POS_W-1:0]    x_limit;
   logic [POS_W-1:0]    y_limit;
   phase_type           phase;
   logic [7:0]          header_byte;
   logic [7:0]          x_delta_byte;
   logic [POS_W-1:0]    cursor_x;
   logic [POS_W-1:0]    cursor_y;
   logic [BUTTON_W-1:0] held_buttons;
   logic [BUTTON_W-1:0] pending_clicks;

   rsp_item_type expected_rsp[$];
   int           fail_total = 0;

   function automatic logic [POS_W-1:0] clamp_pos(input int v, input logic [POS_W-1:0] lim);
      if (v < 0) return '0;
      if (v > int'(lim)) return lim;
      return v[POS_W-1:0];
   endfunction

   task automatic track_item(input req_item_type it, output rsp_item_type res);
      logic [BUTTON_W-1:0] prev;
      logic [BUTTON_W-1:0] clicks_seen;
      byte_status_type     st;
      int                  nx;
      int                  ny;
      st = ST_IGNORED;
      if (it.func) begin
         clicks_seen    = pending_clicks;
         pending_clicks = BUTTON_NONE;
      end else begin
         if (it.buffer_full && it.from_aux) begin
            case (phase)
               PH_XDELTA: begin
                  x_delta_byte = it.data_byte;
                  phase        = PH_YDELTA;
                  st           = ST_STORED;
               end
               PH_YDELTA: begin
                  nx             = int'(cursor_x) + int'($signed(x_delta_byte));
                  ny             = int'(cursor_y) - int'($signed(it.data_byte));
                  prev           = held_buttons;
                  phase          = PH_HEADER;
                  cursor_x       = clamp_pos(nx, x_limit);
                  cursor_y       = clamp_pos(ny, y_limit);
                  held_buttons   = header_byte[BUTTON_W-1:0];
                  pending_clicks = pending_clicks | (held_buttons & ~prev);
                  st             = ST_COMPLETE;
               end
               default: begin
                  // unused phase behaves as header phase
                  header_byte = it.data_byte;
                  if (it.data_byte[SYNC_BIT]) begin
                     phase = PH_XDELTA;
                     st    = ST_STORED;
                  end else begin
                     phase = PH_HEADER;
                     st    = ST_DROPPED;
                  end
               end
            endcase
         end
         clicks_seen = pending_clicks;
      end
      res.byte_status  = st;
      res.pos_x        = cursor_x;
      res.pos_y        = cursor_y;
      res.button_state = held_buttons;
      res.click_mask   = clicks_seen;
   endtask

   task automatic report_mismatch(input string msg);
      if (fail_total < 30) $display("mismatch: %s", msg);
      fail_total++;
   endtask

   always @(posedge clock) begin : monitor
      req_item_type in_item;
      rsp_item_type want;
      if (reset) begin
         x_limit        = X_LIMIT_RESET;
         y_limit        = Y_LIMIT_RESET;
         phase          = PH_HEADER;
         header_byte    = '0;
         x_delta_byte   = '0;
         cursor_x       = CURSOR_X_RESET;
         cursor_y       = CURSOR_Y_RESET;
         held_buttons   = BUTTON_NONE;
         pending_clicks = BUTTON_NONE;
         expected_rsp.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_X_LIMIT: x_limit = csr_wdata;
               CSR_Y_LIMIT: y_limit = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("result transfer with nothing expected");
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_mon.byte_status !== want.byte_status)
                  report_mismatch($sformatf("byte_status got %0d expected %0d",
                                            rsp_mon.byte_status, want.byte_status));
               if (rsp_mon.pos_x !== want.pos_x)
                  report_mismatch($sformatf("pos_x got %0d expected %0d",
                                            rsp_mon.pos_x, want.pos_x));
               if (rsp_mon.pos_y !== want.pos_y)
                  report_mismatch($sformatf("pos_y got %0d expected %0d",
                                            rsp_mon.pos_y, want.pos_y));
               if (rsp_mon.button_state !== want.button_state)
                  report_mismatch($sformatf("button_state got %0d expected %0d",
                                            rsp_mon.button_state, want.button_state));
               if (rsp_mon.click_mask !== want.click_mask)
                  report_mismatch($sformatf("click_mask got %0d expected %0d",
                                            rsp_mon.click_mask, want.click_mask));
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            in_item.func        = req_mon.func;
            in_item.data_byte   = req_mon.data_byte;
            in_item.buffer_full = req_mon.buffer_full;
            in_item.from_aux    = req_mon.from_aux;
            track_item(in_item, want);
            expected_rsp.push_back(want);
         end
      end
      mismatches  <= fail_total;
      outstanding <= expected_rsp.size();
   end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import pmt_pkg::*;

   localparam int DRAIN_CYCLES = 6;
   localparam int PHASES       = 7;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     mismatches;
   int                     outstanding;
   bit                     steady_sender   = 1'b0;
   bit                     steady_receiver = 1'b0;
   int                     ready_left      = 0;

   pmt_req_if req_bus ();
   pmt_rsp_if rsp_bus ();

   ps2_mouse_packet_tracker_unit i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_bus),
      .rsp_if       (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   pmt_tracker_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .outstanding  (outstanding)
   );

   always #5 clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   always @(posedge clock) begin
      if (ready_left > 0) begin
         ready_left--;
      end else if (steady_receiver || rsp_bus.ready !== 1'b1) begin
         rsp_bus.ready <= 1'b1;
         ready_left = $urandom_range(1, 30);
      end else begin
         rsp_bus.ready <= 1'b0;
         ready_left = pick_gap();
      end
   end

   function automatic req_item_type aux_byte(input logic [7:0] b);
      return '{func: 1'b0, data_byte: b, buffer_full: 1'b1, from_aux: 1'b1};
   endfunction

   function automatic req_item_type status_byte(input logic [7:0] b, input logic full,
                                                input logic aux);
      return '{func: 1'b0, data_byte: b, buffer_full: full, from_aux: aux};
   endfunction

   function automatic req_item_type click_read();
      req_item_type it;
      it             = req_item_type'($urandom);
      it.func        = 1'b1;
      return it;
   endfunction

   // byte that the status flags make the block skip
   function automatic req_item_type skipped_byte();
      logic [1:0] flags;
      flags = 2'($urandom_range(0, 2));
      return status_byte(8'($urandom), flags[1], flags[0]);
   endfunction

   function automatic logic [7:0] delta_byte();
      logic [7:0] extremes[5] = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'hff};
      if ($urandom_range(0, 3) == 0) return extremes[$urandom_range(0, 4)];
      return 8'($urandom);
   endfunction

   task automatic send_item(input req_item_type it);
      int gap;
      gap = steady_sender ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.func        <= it.func;
      req_bus.data_byte   <= it.data_byte;
      req_bus.buffer_full <= it.buffer_full;
      req_bus.from_aux    <= it.from_aux;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   task automatic send_packet(input logic [7:0] hdr, input logic [7:0] dx,
                              input logic [7:0] dy);
      send_item(aux_byte(hdr));
      send_item(aux_byte(dx));
      send_item(aux_byte(dy));
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limits(input logic [CSR_DATA_W-1:0] x_lim,
                               input logic [CSR_DATA_W-1:0] y_lim);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_X_LIMIT;
      csr_wdata    <= x_lim;
      @(posedge clock);
      csr_index    <= CSR_Y_LIMIT;
      csr_wdata    <= y_lim;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic random_traffic(input int target);
      int         counted;
      int         pick;
      logic [7:0] hdr;
      req_item_type it;
      counted = 0;
      while (counted < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            hdr           = 8'($urandom);
            hdr[SYNC_BIT] = 1'b1;
            send_item(aux_byte(hdr));
            if ($urandom_range(0, 9) == 0) begin
               send_item(skipped_byte());
               counted++;
            end
            send_item(aux_byte(delta_byte()));
            if ($urandom_range(0, 9) == 0) begin
               send_item(skipped_byte());
               counted++;
            end
            send_item(aux_byte(delta_byte()));
            counted += 3;
         end else if (pick < 80) begin
            send_item(click_read());
            counted++;
         end else if (pick < 90) begin
            it = req_item_type'($urandom);
            it.func = 1'b0;
            send_item(it);
            counted++;
         end else begin
            // broken sequence: lone or unsynced header
            send_item(aux_byte(8'($urandom)));
            counted++;
         end
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] x_set[PHASES] = '{10'd319, 10'd0, 10'd1023, 10'd1, 10'd1023,
                                               10'd0, 10'd40};
      logic [CSR_DATA_W-1:0] y_set[PHASES] = '{10'd199, 10'd0, 10'd1023, 10'd1023, 10'd0,
                                               10'd0, 10'd25};
      req_bus.valid       <= 1'b0;
      req_bus.func        <= 1'b0;
      req_bus.data_byte   <= '0;
      req_bus.buffer_full <= 1'b0;
      req_bus.from_aux    <= 1'b0;
      csr_write_en        <= 1'b0;
      csr_index           <= CSR_X_LIMIT;
      csr_wdata           <= '0;
      x_set[5]            = 10'($urandom);
      y_set[5]            = 10'($urandom);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at reset limits
      send_item(click_read());
      send_item(status_byte(8'hff, 1'b0, 1'b1));
      send_item(status_byte(8'hff, 1'b1, 1'b0));
      send_item(status_byte(8'h00, 1'b0, 1'b0));
      send_item(aux_byte(8'h00));
      send_item(aux_byte(8'hf7));
      send_packet(8'h0f, 8'h7f, 8'h80);
      send_item(click_read());
      send_item(click_read());
      send_item(aux_byte(8'h08));
      send_item(status_byte(8'h55, 1'b1, 1'b0));
      send_item(aux_byte(8'h80));
      send_item(aux_byte(8'h7f));
      send_packet(8'hf9, 8'h7f, 8'h80);
      send_packet(8'h0a, 8'h7f, 8'h00);
      send_packet(8'h0c, 8'h00, 8'h7f);
      send_item(click_read());
      wait_for_results();

      for (int p = 0; p < PHASES; p++) begin
         write_limits(x_set[p], y_set[p]);
         steady_sender   = (p == 2);
         steady_receiver = (p == 2) || (p == 4);
         random_traffic(270);
         wait_for_results();
      end
      steady_sender   = 1'b0;
      steady_receiver = 1'b0;

      if (mismatches == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
src/pmt_pkg.sv
src/pmt_req_if.sv
src/pmt_rsp_if.sv
src/pmt_item_reg.sv
src/pmt_tracker_core.sv
src/pmt_result_reg.sv
src/ps2_mouse_packet_tracker_unit.sv
bench/pmt_tracker_checker.sv
bench/tb.sv
